>>> sv/sppp_pkg.sv
`timescale 1ns / 1ps

package sppp_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_HIGHEST_ID    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'b1;

    localparam logic [3:0] HIGHEST_ID_RST    = 4'd2;
    localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd50;

    localparam logic [1:0] KIND_REPORT    = 2'd0;
    localparam logic [1:0] KIND_MALFORMED = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT   = 2'd2;
    localparam logic [1:0] KIND_REQUEST   = 2'd3;

    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_BANG = 8'h21;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_P    = 8'h50;
    localparam logic [7:0] CHAR_R    = 8'h52;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_D    = 8'h44;

    localparam logic [3:0] LEN_MAX     = 4'd11;
    localparam logic [3:0] LEN_FRAME   = 4'd10;
    localparam logic [3:0] P_INDEX     = 4'd4;
    localparam logic [3:0] P_NONE      = 4'd15;
    localparam logic [3:0] REQ_BYTES   = 4'd9;

    typedef struct packed {
        logic [3:0] highest_id;
        logic [7:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic        timeout;
        logic        request;
        logic        frame;
        logic        frame_ok;
        logic [3:0]  tout_id;
        logic [3:0]  req_id;
        logic [9:0]  servo_id;
        logic [13:0] position;
    } t_job;

    function automatic logic [7:0] req_byte(input logic [3:0] idx, input logic [3:0] id);
        logic [7:0] b;
        case (idx)
            4'd0: b = CHAR_HASH;
            4'd1: b = CHAR_ZERO;
            4'd2: b = CHAR_ZERO;
            4'd3: b = CHAR_ZERO + {4'd0, id};
            4'd4: b = CHAR_P;
            4'd5: b = CHAR_R;
            4'd6: b = CHAR_A;
            4'd7: b = CHAR_D;
            default: b = CHAR_BANG;
        endcase
        return b;
    endfunction

endpackage

>>> sv/sppp_in_if.sv
`timescale 1ns / 1ps

interface sppp_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, command, rx_byte, input ready);
    modport sink   (input valid, command, rx_byte, output ready);
endinterface

>>> sv/sppp_out_if.sv
`timescale 1ns / 1ps

interface sppp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [9:0]  servo_id;
    logic [13:0] position;
    logic [7:0]  tx_byte;
    logic        last;

    modport source (output valid, kind, servo_id, position, tx_byte, last, input ready);
    modport sink   (input valid, kind, servo_id, position, tx_byte, last, output ready);
endinterface

>>> sv/sppp_front.sv
`timescale 1ns / 1ps

module sppp_front
    import sppp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    sppp_in_if.sink    i_in,
    input  t_cfg       i_cfg,
    input  logic       i_full,
    output logic       o_push,
    output t_job       o_job
);

    logic        r_poll_waiting, n_poll_waiting;
    logic [3:0]  r_waited_id,    n_waited_id;
    logic [3:0]  r_next_id,      n_next_id;
    logic [7:0]  r_tick_count,   n_tick_count;
    logic        r_in_frame,     n_in_frame;
    logic [3:0]  r_frame_len,    n_frame_len;
    logic [3:0]  r_first_p,      n_first_p;
    logic [9:0]  r_id_acc,       n_id_acc;
    logic [13:0] r_pos_acc,      n_pos_acc;
    logic        r_digits_ok,    n_digits_ok;

    logic       accept;
    logic       timeout;
    logic       waiting;
    logic [3:0] id_inc;
    logic [7:0] b;
    logic       is_digit;
    logic       id_slot;
    logic       pos_slot;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign b          = i_in.rx_byte;
    assign is_digit   = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    assign id_slot    = (r_frame_len >= 4'd1) && (r_frame_len <= 4'd3);
    assign pos_slot   = (r_frame_len >= 4'd5) && (r_frame_len <= 4'd8);
    assign timeout    = r_tick_count > i_cfg.timeout_ticks;
    assign waiting    = r_poll_waiting && !timeout;
    assign id_inc     = r_next_id + 4'd1;

    always_comb begin
        n_poll_waiting = r_poll_waiting;
        n_waited_id    = r_waited_id;
        n_next_id      = r_next_id;
        n_tick_count   = r_tick_count;
        n_in_frame     = r_in_frame;
        n_frame_len    = r_frame_len;
        n_first_p      = r_first_p;
        n_id_acc       = r_id_acc;
        n_pos_acc      = r_pos_acc;
        n_digits_ok    = r_digits_ok;
        o_push         = 1'b0;
        o_job          = '0;
        o_job.tout_id  = r_waited_id;
        o_job.req_id   = r_next_id;
        if (accept) begin
            if (i_in.command) begin
                o_job.timeout  = timeout;
                o_job.request  = !waiting;
                o_push         = timeout || !waiting;
                n_poll_waiting = 1'b1;
                n_tick_count   = (timeout ? 8'd0 : r_tick_count) + 8'd1;
                if (!waiting) begin
                    n_waited_id = r_next_id;
                    n_next_id   = (id_inc > i_cfg.highest_id) ? 4'd0 : id_inc;
                end
            end else if (!r_in_frame) begin
                if (b == CHAR_HASH) begin
                    n_in_frame  = 1'b1;
                    n_frame_len = 4'd1;
                    n_first_p   = P_NONE;
                    n_id_acc    = '0;
                    n_pos_acc   = '0;
                    n_digits_ok = 1'b1;
                end
            end else begin
                if (r_frame_len < LEN_MAX) begin
                    n_frame_len = r_frame_len + 4'd1;
                end
                if (b == CHAR_P && r_first_p == P_NONE) begin
                    n_first_p = r_frame_len;
                end
                if (id_slot || pos_slot) begin
                    if (!is_digit) begin
                        n_digits_ok = 1'b0;
                    end else if (id_slot) begin
                        n_id_acc = 10'(r_id_acc * 10'd10 + {6'd0, b[3:0]});
                    end else begin
                        n_pos_acc = 14'(r_pos_acc * 14'd10 + {10'd0, b[3:0]});
                    end
                end
                if (b == CHAR_BANG) begin
                    o_push         = 1'b1;
                    o_job.frame    = 1'b1;
                    o_job.frame_ok = (n_frame_len == LEN_FRAME) && (n_first_p == P_INDEX)
                                     && n_digits_ok;
                    o_job.servo_id = n_id_acc;
                    o_job.position = n_pos_acc;
                    n_poll_waiting = 1'b0;
                    n_tick_count   = '0;
                    n_in_frame     = 1'b0;
                    n_frame_len    = '0;
                    n_first_p      = P_NONE;
                    n_id_acc       = '0;
                    n_pos_acc      = '0;
                    n_digits_ok    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_waiting <= 1'b0;
            r_waited_id    <= '0;
            r_next_id      <= '0;
            r_tick_count   <= '0;
            r_in_frame     <= 1'b0;
            r_frame_len    <= '0;
            r_first_p      <= P_NONE;
            r_id_acc       <= '0;
            r_pos_acc      <= '0;
            r_digits_ok    <= 1'b1;
        end else begin
            r_poll_waiting <= n_poll_waiting;
            r_waited_id    <= n_waited_id;
            r_next_id      <= n_next_id;
            r_tick_count   <= n_tick_count;
            r_in_frame     <= n_in_frame;
            r_frame_len    <= n_frame_len;
            r_first_p      <= n_first_p;
            r_id_acc       <= n_id_acc;
            r_pos_acc      <= n_pos_acc;
            r_digits_ok    <= n_digits_ok;
        end
    end

    a_tick_leaves_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.command) |=> r_poll_waiting)
        else $error("A poll is not waiting after a tick.");

    a_len_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frame_len <= LEN_MAX) && (r_in_frame || r_frame_len == 4'd0))
        else $error("Frame length out of range.");

endmodule

>>> sv/sppp_queue.sv
`timescale 1ns / 1ps

module sppp_queue
    import sppp_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("Job queue written while full.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("Job queue read while empty.");

endmodule

>>> sv/sppp_back.sv
`timescale 1ns / 1ps

module sppp_back
    import sppp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_job        i_head,
    output logic        o_pop,
    sppp_out_if.source  o_out
);

    logic        r_valid,    n_valid;
    logic [3:0]  r_seq,      n_seq;
    logic [1:0]  r_kind,     n_kind;
    logic [9:0]  r_servo_id, n_servo_id;
    logic [13:0] r_position, n_position;
    logic [7:0]  r_tx_byte,  n_tx_byte;
    logic        r_last,     n_last;

    logic       load;
    logic [3:0] n_items;
    logic [3:0] req_idx;

    assign load    = !i_empty && (!r_valid || o_out.ready);
    assign n_items = {3'd0, i_head.timeout} + (i_head.request ? REQ_BYTES : 4'd0);
    assign req_idx = r_seq - {3'd0, i_head.timeout};

    always_comb begin
        n_kind     = KIND_REQUEST;
        n_servo_id = '0;
        n_position = '0;
        n_tx_byte  = '0;
        n_last     = 1'b0;
        if (i_head.frame) begin
            n_last = 1'b1;
            if (i_head.frame_ok) begin
                n_kind     = KIND_REPORT;
                n_servo_id = i_head.servo_id;
                n_position = i_head.position;
            end else begin
                n_kind = KIND_MALFORMED;
            end
        end else begin
            n_last = (r_seq == n_items - 4'd1);
            if (i_head.timeout && r_seq == 4'd0) begin
                n_kind     = KIND_TIMEOUT;
                n_servo_id = {6'd0, i_head.tout_id};
            end else begin
                n_tx_byte = req_byte(req_idx, i_head.req_id);
            end
        end
    end

    assign o_pop = load && n_last;

    always_comb begin
        n_valid = r_valid;
        n_seq   = r_seq;
        if (load) begin
            n_valid = 1'b1;
            n_seq   = n_last ? 4'd0 : r_seq + 4'd1;
        end else if (o_out.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_seq   <= '0;
        end else begin
            r_valid <= n_valid;
            r_seq   <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind     <= n_kind;
            r_servo_id <= n_servo_id;
            r_position <= n_position;
            r_tx_byte  <= n_tx_byte;
            r_last     <= n_last;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.kind     = r_kind;
    assign o_out.servo_id = r_servo_id;
    assign o_out.position = r_position;
    assign o_out.tx_byte  = r_tx_byte;
    assign o_out.last     = r_last;

    a_seq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq <= REQ_BYTES)
        else $error("Result sequence counter out of range.");

endmodule

>>> sv/servo_position_poll_parser_unit.sv
`timescale 1ns / 1ps

// Polls serial servos and parses their ASCII position replies. The front end takes one input
// item per clock cycle while its job queue has room and leaves one job per item that causes
// results; the back end turns each job into result items at one per cycle while the output
// is ready, through a registered output stage; a tick that starts a poll gives nine or ten
// items and a finished frame one. An item's first result passes the job queue and then the
// output stage when the back end is free; the queue depth sets how many such jobs may wait
// while the output is stalled or busy. Configuration writes take effect at the next cycle.

module servo_position_poll_parser_unit
    import sppp_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sppp_in_if.sink               i_in,
    sppp_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic full;
    logic empty;
    logic push;
    logic pop;
    t_job job;
    t_job head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.highest_id    <= HIGHEST_ID_RST;
            r_cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_HIGHEST_ID:    r_cfg.highest_id    <= i_cfg_data[3:0];
                REG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    sppp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job)
    );

    sppp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    sppp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

>>> tb/sv/servo_position_poll_parser_unit_checker.sv
`timescale 1ns / 1ps

module servo_position_poll_parser_unit_checker
    import sppp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sppp_in_if                    i_in_ch,
    sppp_out_if                   i_out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  servo_id;
        logic [13:0] position;
        logic [7:0]  tx_byte;
        logic        last;
    } t_parser_out;

    t_parser_out expected_out[$];
    t_parser_out seen;
    t_parser_out want;
    int          mismatches = 0;

    logic [3:0]  highest_id;
    logic [7:0]  tout_limit;

    logic        poll_waiting;
    logic [3:0]  waited_id;
    logic [3:0]  next_id;
    logic [7:0]  tick_count;
    logic        in_frame;
    logic [3:0]  frame_len;
    logic [3:0]  first_p;
    logic [9:0]  id_acc;
    logic [13:0] pos_acc;
    logic        digits_ok;

    task automatic expect_out(input logic [1:0] kind, input logic [9:0] id,
                              input logic [13:0] pos, input logic [7:0] tx);
        t_parser_out entry;
        entry = '{kind, id, pos, tx, 1'b0};
        expected_out.insert(expected_out.size(), entry);
    endtask

    task automatic clear_frame();
        in_frame  = 1'b0;
        frame_len = '0;
        first_p   = P_NONE;
        id_acc    = '0;
        pos_acc   = '0;
        digits_ok = 1'b1;
    endtask

    task automatic predict_step(input logic is_tick, input logic [7:0] rx);
        logic [7:0]  request [9];
        logic [3:0]  idx;
        logic        is_digit;
        int          before_count;
        t_parser_out tail;
        before_count = expected_out.size();
        if (is_tick) begin
            if (tick_count > tout_limit) begin
                tick_count   = '0;
                poll_waiting = 1'b0;
                expect_out(KIND_TIMEOUT, {6'd0, waited_id}, '0, '0);
            end
            if (!poll_waiting) begin
                request = '{CHAR_HASH, CHAR_ZERO, CHAR_ZERO, CHAR_ZERO + {4'd0, next_id},
                            CHAR_P, CHAR_R, CHAR_A, CHAR_D, CHAR_BANG};
                foreach (request[i]) begin
                    expect_out(KIND_REQUEST, '0, '0, request[i]);
                end
                waited_id    = next_id;
                poll_waiting = 1'b1;
                next_id      = next_id + 4'd1;
                if (next_id > highest_id) begin
                    next_id = '0;
                end
            end
            tick_count = tick_count + 8'd1;
        end else if (!in_frame) begin
            if (rx == CHAR_HASH) begin
                clear_frame();
                in_frame  = 1'b1;
                frame_len = 4'd1;
            end
        end else begin
            idx      = frame_len;
            is_digit = (rx >= CHAR_ZERO) && (rx <= CHAR_NINE);
            if (frame_len < LEN_MAX) begin
                frame_len = frame_len + 4'd1;
            end
            if (rx == CHAR_P && first_p == P_NONE) begin
                first_p = idx;
            end
            // The id digits lie between the hash and the P, the position digits after it.
            if ((idx >= 4'd1 && idx < P_INDEX) || (idx > P_INDEX && idx < LEN_FRAME - 4'd1)) begin
                if (!is_digit) begin
                    digits_ok = 1'b0;
                end else if (idx < P_INDEX) begin
                    id_acc = 10'(id_acc * 10'd10 + 10'(rx - CHAR_ZERO));
                end else begin
                    pos_acc = 14'(pos_acc * 14'd10 + 14'(rx - CHAR_ZERO));
                end
            end
            if (rx == CHAR_BANG) begin
                if (frame_len == LEN_FRAME && first_p == P_INDEX && digits_ok) begin
                    expect_out(KIND_REPORT, id_acc, pos_acc, '0);
                end else begin
                    expect_out(KIND_MALFORMED, '0, '0, '0);
                end
                poll_waiting = 1'b0;
                tick_count   = '0;
                clear_frame();
            end
        end
        if (expected_out.size() > before_count) begin
            tail      = expected_out[$];
            tail.last = 1'b1;
            expected_out[expected_out.size() - 1] = tail;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            highest_id   = HIGHEST_ID_RST;
            tout_limit   = TIMEOUT_TICKS_RST;
            poll_waiting = 1'b0;
            waited_id    = '0;
            next_id      = '0;
            tick_count   = '0;
            clear_frame();
            expected_out.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_HIGHEST_ID: begin
                        highest_id = i_cfg_data[3:0];
                    end
                    REG_TIMEOUT_TICKS: begin
                        tout_limit = i_cfg_data[7:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                predict_step(i_in_ch.command, i_in_ch.rx_byte);
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                seen = '{i_out_ch.kind, i_out_ch.servo_id, i_out_ch.position,
                         i_out_ch.tx_byte, i_out_ch.last};
                if (expected_out.size() == 0) begin
                    $display("%0t ns: unexpected item kind %0d id %0d position %0d tx %02h last %0b",
                             $time, seen.kind, seen.servo_id, seen.position, seen.tx_byte,
                             seen.last);
                    mismatches++;
                end else begin
                    want = expected_out.pop_front();
                    if (seen.kind !== want.kind || seen.servo_id !== want.servo_id ||
                        seen.position !== want.position || seen.tx_byte !== want.tx_byte ||
                        seen.last !== want.last) begin
                        $display("%0t ns: expected kind %0d id %0d position %0d tx %02h last %0b",
                                 $time, want.kind, want.servo_id, want.position, want.tx_byte,
                                 want.last);
                        $display("%0t ns:      got kind %0d id %0d position %0d tx %02h last %0b",
                                 $time, seen.kind, seen.servo_id, seen.position, seen.tx_byte,
                                 seen.last);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= expected_out.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> tb/sv/servo_position_poll_parser_unit_tb.sv
`timescale 1ns / 1ps

module servo_position_poll_parser_unit_tb;
    import sppp_pkg::*;

    localparam logic CMD_BYTE      = 1'b0;
    localparam logic CMD_TICK      = 1'b1;
    localparam int   CYCLE_LIMIT   = 300000;
    localparam int   SETTLE_CYCLES = 8;
    localparam int   PHASES        = 4;
    localparam int   PHASE_ITEMS   = 72;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending_count;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int cycle_count = 0;
    int items_sent  = 0;

    int phase_highest [PHASES] = '{0, 9, 15, 5};
    int phase_timeout [PHASES] = '{0, 3, 1, 255};
    int phase_idle    [PHASES] = '{63, 0, 12, 0};
    int phase_stall   [PHASES] = '{0, 63, 12, 0};

    sppp_in_if  in_ch ();
    sppp_out_if out_ch ();

    servo_position_poll_parser_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    servo_position_poll_parser_unit_checker CHECK (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count  <= cycle_count + 1;
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_item(input logic cmd, input logic [7:0] data);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.command <= cmd;
        in_ch.rx_byte <= data;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            push_item(CMD_BYTE, text[i]);
        end
    endtask

    // Holds the sender off until every predicted item has come out.
    task automatic wait_quiet(input int settle);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
        repeat (settle) @(posedge i_clk);
    endtask

    initial begin
        logic [7:0] reply[$];
        int         roll;
        int         phase_start;
        in_ch.valid   <= 1'b0;
        in_ch.command <= CMD_BYTE;
        in_ch.rx_byte <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_HIGHEST_ID;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A full-scale report, stray bytes outside a frame, a hash inside a frame and
        // three polls so that the servo id wraps at the reset setting.
        push_item(CMD_TICK, 8'hFF);
        send_text("#999P9999!");
        push_item(CMD_BYTE, 8'h00);
        push_item(CMD_BYTE, 8'hFF);
        push_item(CMD_BYTE, CHAR_BANG);
        push_item(CMD_TICK, 8'h00);
        send_text("##:/P0000!");
        push_item(CMD_TICK, 8'h00);

        for (int p = 0; p < PHASES; p++) begin
            wait_quiet(SETTLE_CYCLES);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= REG_HIGHEST_ID;
            i_cfg_data <= CFG_DATA_W'(phase_highest[p]);
            @(posedge i_clk);
            i_cfg_idx  <= REG_TIMEOUT_TICKS;
            i_cfg_data <= CFG_DATA_W'(phase_timeout[p]);
            @(posedge i_clk);
            i_cfg_we  <= 1'b0;
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                roll = $urandom_range(99);
                reply.delete();
                if (roll < 30) begin
                    push_item(CMD_TICK, 8'($urandom_range(255)));
                end else if (roll < 80) begin
                    reply.insert(reply.size(), CHAR_HASH);
                    repeat (3) reply.insert(reply.size(), CHAR_ZERO + 8'($urandom_range(9)));
                    reply.insert(reply.size(), CHAR_P);
                    repeat (4) reply.insert(reply.size(), CHAR_ZERO + 8'($urandom_range(9)));
                    reply.insert(reply.size(), CHAR_BANG);
                    // A quarter of the replies have one byte damaged.
                    if ($urandom_range(3) == 0) begin
                        reply[$urandom_range(9, 1)] = 8'($urandom_range(255));
                    end
                end else if (roll < 90) begin
                    reply.insert(reply.size(), CHAR_HASH);
                    repeat ($urandom_range(13)) reply.insert(reply.size(), 8'($urandom_range(255)));
                    reply.insert(reply.size(), CHAR_BANG);
                end else begin
                    reply.insert(reply.size(), 8'($urandom_range(255)));
                end
                foreach (reply[i]) begin
                    push_item(CMD_BYTE, reply[i]);
                end
            end
        end

        wait_quiet(20);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
